@@ design/dtt_pkg.sv @@
`default_nettype none

package dtt_pkg;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  localparam logic [1:0] REG_DIV = 2'd0;
  localparam logic [1:0] REG_CNT = 2'd1;
  localparam logic [1:0] REG_MOD = 2'd2;
  localparam logic [1:0] REG_CTL = 2'd3;

  localparam int CountdownWidth = 12;
  localparam logic [CountdownWidth-1:0] COUNTDOWN_RESET = 12'd1024;

  localparam int CtlEnableBit = 2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] cycles;
    logic [1:0] reg_sel;
    logic [7:0] write_data;
  } dtt_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } dtt_rsp_t;

  function automatic logic [CountdownWidth-1:0] rate_period(input logic [1:0] rate);
    logic [CountdownWidth-1:0] period;
    case (rate)
      2'd0:    period = 12'd1024;
      2'd1:    period = 12'd16;
      2'd2:    period = 12'd64;
      2'd3:    period = 12'd256;
      default: period = 12'd1024;
    endcase
    return period;
  endfunction

endpackage

`default_nettype wire

@@ design/dtt_state.sv @@
`default_nettype none

module dtt_state
  import dtt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire dtt_req_t req,
  output dtt_rsp_t      rsp
);

  logic [7:0]                div_reg, div_reg_next;
  logic [7:0]                cnt_reg, cnt_reg_next;
  logic [7:0]                mod_reg, mod_reg_next;
  logic [7:0]                ctl_reg, ctl_reg_next;
  logic [7:0]                prescale, prescale_next;
  logic [CountdownWidth-1:0] countdown, countdown_next;

  logic [8:0]                pre_sum;
  logic [CountdownWidth-1:0] cyc_ext;

  always_comb begin
    div_reg_next   = div_reg;
    cnt_reg_next   = cnt_reg;
    mod_reg_next   = mod_reg;
    ctl_reg_next   = ctl_reg;
    prescale_next  = prescale;
    countdown_next = countdown;
    rsp            = '0;
    pre_sum        = {1'b0, prescale} + {1'b0, req.cycles};
    cyc_ext        = {{(CountdownWidth-8){1'b0}}, req.cycles};

    case (req.func)
      FUNC_TICK: begin
        prescale_next = pre_sum[7:0];
        if (pre_sum[8]) begin
          div_reg_next = div_reg + 8'd1;
        end
        if (ctl_reg[CtlEnableBit]) begin
          if (countdown <= cyc_ext) begin
            countdown_next = rate_period(ctl_reg[1:0]);
            if (cnt_reg == 8'hFF) begin
              cnt_reg_next  = mod_reg;
              rsp.timer_irq = 1'b1;
            end else begin
              cnt_reg_next = cnt_reg + 8'd1;
            end
          end else begin
            countdown_next = countdown - cyc_ext;
          end
        end
      end
      FUNC_READ: begin
        case (req.reg_sel)
          REG_DIV: rsp.read_data = div_reg;
          REG_CNT: rsp.read_data = cnt_reg;
          REG_MOD: rsp.read_data = mod_reg;
          REG_CTL: rsp.read_data = ctl_reg;
          default: rsp.read_data = '0;
        endcase
      end
      FUNC_WRITE: begin
        case (req.reg_sel)
          REG_DIV: div_reg_next = req.write_data;
          REG_CNT: cnt_reg_next = req.write_data;
          REG_MOD: mod_reg_next = req.write_data;
          REG_CTL: ctl_reg_next = req.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_reg   <= '0;
      cnt_reg   <= '0;
      mod_reg   <= '0;
      ctl_reg   <= '0;
      prescale  <= '0;
      countdown <= COUNTDOWN_RESET;
    end else if (fire) begin
      div_reg   <= div_reg_next;
      cnt_reg   <= cnt_reg_next;
      mod_reg   <= mod_reg_next;
      ctl_reg   <= ctl_reg_next;
      prescale  <= prescale_next;
      countdown <= countdown_next;
    end
  end

endmodule

`default_nettype wire

@@ design/dtt_out_reg.sv @@
`default_nettype none

module dtt_out_reg
  import dtt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     load,
  input  wire dtt_rsp_t rsp_in,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output dtt_rsp_t      rsp,
  output logic          ready
);

  assign ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ready) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      rsp <= rsp_in;
    end
  end

endmodule

`default_nettype wire

@@ design/div_tima_timer_core.sv @@
// Divider / counter timer with four byte registers: divider, counter,
// modulo and control.
// Request channel (req_valid, req_stall, req): each transfer is a tick of
// req.cycles clocks, a register read or a register write, picked by req.func.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one response per
// request, in order; read_data carries the register on a read, timer_irq is
// set when a tick overflowed the counter.
// Pipeline: a request is captured in an input register, processed against the
// timer state by combinational add, compare and increment logic, and its
// response is loaded into the output register, which raises rsp_valid.
// Throughput: one request per cycle while no response is stalled; the state
// update is combinational, so the next request always sees the updated state.
// Stall: while rsp_stall holds a response, the output register freezes, and
// once the input register is occupied it freezes too and req_stall rises.
// Reset: all registers and the prescaler clear, the countdown loads 1024, and
// both pipeline registers empty.
`default_nettype none

module div_tima_timer_core
  import dtt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire dtt_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output dtt_rsp_t      rsp
);

  logic     held_valid;
  dtt_req_t held;
  logic     advance;
  logic     fire;
  dtt_rsp_t result;

  assign req_stall = held_valid && !advance;
  assign fire      = held_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!req_stall) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      held <= req;
    end
  end

  dtt_state u_state (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (held),
    .rsp  (result)
  );

  dtt_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (held_valid),
    .rsp_in    (result),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .ready     (advance)
  );

endmodule

`default_nettype wire
